// ===== hdl/rrd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rrd_pkg
// Shared types and constants for the ray/ray line distance pipeline.
// ---------------------------------------------------------------------------
package rrd_pkg;

	// digit width of the multiplier partial products
	localparam int MUL_DIGIT = 32;

	// result width (unsigned fixed point, same fraction bits as the inputs)
	localparam int DIST_W = 32;
	localparam int STAT_W = 2;

	// root unit: one range check stage plus one stage per result bit
	localparam int ROOT_LAT = DIST_W + 1;

	typedef enum logic [STAT_W-1:0] {
		ST_SKEW = 2'd0,
		ST_PAR  = 2'd1,
		ST_ZERO = 2'd2,
		ST_SAT  = 2'd3
	} rrd_status_t;

	// latency of rrd_mul for the given operand widths
	function automatic int mul_lat(input int aw, input int bw);
		return ((aw + MUL_DIGIT - 1) / MUL_DIGIT) * ((bw + MUL_DIGIT - 1) / MUL_DIGIT) + 1;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/rrd_dly.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rrd_dly
// Side-band delay line with valid bit; keeps flags and operands aligned
// with a multiplier or root unit of the same latency.
// ---------------------------------------------------------------------------
module rrd_dly #(
	parameter int DW = 8,
	parameter int N  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] d,
	output logic          out_valid,
	output logic [DW-1:0] q
);

	logic          vld_q [N];
	logic [DW-1:0] dat_q [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic          vld_prev;
		logic [DW-1:0] dat_prev;

		if (k == 0) begin : g_first
			assign vld_prev = in_valid;
			assign dat_prev = d;
		end else begin : g_next
			assign vld_prev = vld_q[k-1];
			assign dat_prev = dat_q[k-1];
		end

		// valid needs reset, data does not
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dat_q[k] <= dat_prev;
			end
		end
	end

	assign out_valid = vld_q[N-1];
	assign q         = dat_q[N-1];

endmodule
`default_nettype wire

// ===== hdl/rrd_mul.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rrd_mul
// Pipelined signed multiplier: sign/magnitude form, one 32x32 partial
// product accumulated per stage, sign applied in the output register.
// ---------------------------------------------------------------------------
module rrd_mul
	import rrd_pkg::*;
#(
	parameter int AW = 33,
	parameter int BW = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);

	localparam int NA = (AW + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int NB = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int NS = NA * NB;
	localparam int AP = NA * MUL_DIGIT;
	localparam int BP = NB * MUL_DIGIT;
	localparam int EW = AP + BP;
	localparam int PW = AW + BW;

	logic [AW-1:0] a_abs;
	logic [BW-1:0] b_abs;
	logic [AP-1:0] a_mag;
	logic [BP-1:0] b_mag;
	logic          neg_in;

	// magnitudes; the most negative value maps to its exact unsigned size
	always_comb begin
		a_abs  = a[AW-1] ? (~a + 1'b1) : a;
		b_abs  = b[BW-1] ? (~b + 1'b1) : b;
		a_mag  = AP'(a_abs);
		b_mag  = BP'(b_abs);
		neg_in = a[AW-1] ^ b[BW-1];
	end

	logic [AP-1:0] a_q   [NS];
	logic [BP-1:0] b_q   [NS];
	logic [EW-1:0] acc_q [NS];
	logic          neg_q [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int I = k / NB;
		localparam int J = k % NB;

		logic [AP-1:0]            a_prev;
		logic [BP-1:0]            b_prev;
		logic [EW-1:0]            acc_prev;
		logic                     neg_prev;
		logic [2*MUL_DIGIT-1:0]   pp;

		if (k == 0) begin : g_first
			assign a_prev   = a_mag;
			assign b_prev   = b_mag;
			assign acc_prev = '0;
			assign neg_prev = neg_in;
		end else begin : g_next
			assign a_prev   = a_q[k-1];
			assign b_prev   = b_q[k-1];
			assign acc_prev = acc_q[k-1];
			assign neg_prev = neg_q[k-1];
		end

		// one digit product per stage
		assign pp = a_prev[I*MUL_DIGIT +: MUL_DIGIT] * b_prev[J*MUL_DIGIT +: MUL_DIGIT];

		always_ff @(posedge clk) begin
			if (en) begin
				a_q[k]   <= a_prev;
				b_q[k]   <= b_prev;
				neg_q[k] <= neg_prev;
				acc_q[k] <= acc_prev + (EW'(pp) << ((I + J) * MUL_DIGIT));
			end
		end
	end

	logic [PW-1:0] mag_last;
	logic [PW-1:0] p_q;

	assign mag_last = acc_q[NS-1][PW-1:0];

	// apply sign
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= neg_q[NS-1] ? (~mag_last + 1'b1) : mag_last;
		end
	end

	assign p = p_q;

endmodule
`default_nettype wire

// ===== hdl/rrd_root.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rrd_root
// Pipelined ratio root: largest r < 2^32 with r*r*den <= num, one result
// bit per stage, using running r*r*den and r*den so each stage is adds only.
// ---------------------------------------------------------------------------
module rrd_root
	import rrd_pkg::*;
#(
	parameter int NW = 268,
	parameter int DW = 134
) (
	input  logic              clk,
	input  logic              en,
	input  logic [NW-1:0]     num,
	input  logic [DW-1:0]     den,
	output logic [DIST_W-1:0] root,
	output logic              sat
);

	localparam int RDW = DW + DIST_W;
	localparam int CW  = ((NW > DW + 2 * DIST_W) ? NW : DW + 2 * DIST_W) + 2;

	logic [NW-1:0]     num_q [DIST_W+1];
	logic [DW-1:0]     den_q [DIST_W+1];
	logic [NW-1:0]     t_q   [DIST_W+1];
	logic [RDW-1:0]    rd_q  [DIST_W+1];
	logic [DIST_W-1:0] r_q   [DIST_W+1];
	logic              sat_q [DIST_W+1];

	// range check: r would reach 2^32
	always_ff @(posedge clk) begin
		if (en) begin
			num_q[0] <= num;
			den_q[0] <= den;
			t_q[0]   <= '0;
			rd_q[0]  <= '0;
			r_q[0]   <= '0;
			sat_q[0] <= (CW'(den) << (2 * DIST_W)) <= CW'(num);
		end
	end

	for (genvar k = 1; k <= DIST_W; k++) begin : g_bit
		localparam int B = DIST_W - k;

		logic [CW-1:0] cand;
		logic          fit;

		// (r + 2^B)^2 * den = t + r*den*2^(B+1) + den*2^(2B)
		assign cand = CW'(t_q[k-1]) + (CW'(rd_q[k-1]) << (B + 1))
			+ (CW'(den_q[k-1]) << (2 * B));
		assign fit  = cand <= CW'(num_q[k-1]);

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k] <= num_q[k-1];
				den_q[k] <= den_q[k-1];
				sat_q[k] <= sat_q[k-1];
				t_q[k]   <= fit ? cand[NW-1:0] : t_q[k-1];
				rd_q[k]  <= fit ? rd_q[k-1] + (RDW'(den_q[k-1]) << B) : rd_q[k-1];
				r_q[k]   <= fit ? r_q[k-1] | (DIST_W'(1) << B) : r_q[k-1];
			end
		end
	end

	assign root = r_q[DIST_W];
	assign sat  = sat_q[DIST_W];

endmodule
`default_nettype wire

// ===== hdl/ray_ray_distance.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ray_ray_distance
// Shortest distance between the lines of two rays in signed fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel ray_valid/ray_ready carries one ray pair per item: origin
//   and direction of each ray, COORD_WIDTH-bit signed fixed point. Output
//   channel dist_valid/dist_ready carries distance (unsigned, same fraction
//   bits) and status (skew, parallel, zero first direction, saturated).
//   Throughput is one item per cycle unless the output stalls. Each
//   multiplier layer accumulates its digit products one per stage; the
//   33-stage root unit and the 25-digit square of the dot product are
//   the deepest parts. All stages advance together: when the output holds
//   an item that is not taken, the whole pipeline holds and ray_ready is
//   low; empty stages do not hold it. Reset clears all valid bits; no item
//   is in flight after it.
// ---------------------------------------------------------------------------
module ray_ray_distance
	import rrd_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ray_valid,
	output logic                          ray_ready,
	input  logic signed [COORD_WIDTH-1:0] first_origin_x,
	input  logic signed [COORD_WIDTH-1:0] first_origin_y,
	input  logic signed [COORD_WIDTH-1:0] first_origin_z,
	input  logic signed [COORD_WIDTH-1:0] first_dir_x,
	input  logic signed [COORD_WIDTH-1:0] first_dir_y,
	input  logic signed [COORD_WIDTH-1:0] first_dir_z,
	input  logic signed [COORD_WIDTH-1:0] second_origin_x,
	input  logic signed [COORD_WIDTH-1:0] second_origin_y,
	input  logic signed [COORD_WIDTH-1:0] second_origin_z,
	input  logic signed [COORD_WIDTH-1:0] second_dir_x,
	input  logic signed [COORD_WIDTH-1:0] second_dir_y,
	input  logic signed [COORD_WIDTH-1:0] second_dir_z,
	output logic                          dist_valid,
	input  logic                          dist_ready,
	output logic [DIST_W-1:0]             distance,
	output logic [STAT_W-1:0]             status
);

	localparam int W   = COORD_WIDTH;
	localparam int DLW = W + 1;          // origin difference
	localparam int PW1 = DLW + W;        // cross term product
	localparam int VW  = PW1 + 1;        // cross component
	localparam int SW  = 2 * VW + 2;     // sum of three products
	localparam int NW  = 2 * SW;         // squared dot product
	localparam int L1  = mul_lat(DLW, W);
	localparam int L2  = mul_lat(VW, VW);
	localparam int L3  = mul_lat(SW, SW);

	logic pipe_en;

	// global advance: hold everything while the output item waits
	assign pipe_en   = !dist_valid || dist_ready;
	assign ray_ready = pipe_en;

	// ---- stage 1: register inputs, origin difference ----
	logic signed [W-1:0] o1_c [3];
	logic signed [W-1:0] o2_c [3];
	logic signed [W-1:0] d1_c [3];
	logic signed [W-1:0] d2_c [3];

	assign o1_c[0] = first_origin_x;
	assign o1_c[1] = first_origin_y;
	assign o1_c[2] = first_origin_z;
	assign o2_c[0] = second_origin_x;
	assign o2_c[1] = second_origin_y;
	assign o2_c[2] = second_origin_z;
	assign d1_c[0] = first_dir_x;
	assign d1_c[1] = first_dir_y;
	assign d1_c[2] = first_dir_z;
	assign d2_c[0] = second_dir_x;
	assign d2_c[1] = second_dir_y;
	assign d2_c[2] = second_dir_z;

	logic signed [DLW-1:0] dl_s1 [3];
	logic signed [W-1:0]   d1_s1 [3];
	logic signed [W-1:0]   d2_s1 [3];
	logic                  vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= ray_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int i = 0; i < 3; i++) begin
				dl_s1[i] <= DLW'(o2_c[i]) - DLW'(o1_c[i]);
				d1_s1[i] <= d1_c[i];
				d2_s1[i] <= d2_c[i];
			end
		end
	end

	// ---- layer 1: v = d1 x d2, w = dl x d1 ----
	logic signed [PW1-1:0] pva [3];
	logic signed [PW1-1:0] pvb [3];
	logic signed [PW1-1:0] pwa [3];
	logic signed [PW1-1:0] pwb [3];

	for (genvar i = 0; i < 3; i++) begin : g_cross
		localparam int I1 = (i + 1) % 3;
		localparam int I2 = (i + 2) % 3;

		rrd_mul #(.AW(DLW), .BW(W)) u_va (
			.clk(clk), .en(pipe_en),
			.a(DLW'(d1_s1[I1])), .b(d2_s1[I2]), .p(pva[i])
		);
		rrd_mul #(.AW(DLW), .BW(W)) u_vb (
			.clk(clk), .en(pipe_en),
			.a(DLW'(d1_s1[I2])), .b(d2_s1[I1]), .p(pvb[i])
		);
		rrd_mul #(.AW(DLW), .BW(W)) u_wa (
			.clk(clk), .en(pipe_en),
			.a(dl_s1[I1]), .b(d1_s1[I2]), .p(pwa[i])
		);
		rrd_mul #(.AW(DLW), .BW(W)) u_wb (
			.clk(clk), .en(pipe_en),
			.a(dl_s1[I2]), .b(d1_s1[I1]), .p(pwb[i])
		);
	end

	logic [3*W+3*DLW-1:0] side1_d;
	logic [3*W+3*DLW-1:0] side1_q;
	logic                 vld_d1;

	assign side1_d = {d1_s1[0], d1_s1[1], d1_s1[2], dl_s1[0], dl_s1[1], dl_s1[2]};

	rrd_dly #(.DW(3*W+3*DLW), .N(L1)) u_dly1 (
		.clk(clk), .arst_n(arst_n), .en(pipe_en),
		.in_valid(vld_s1), .d(side1_d), .out_valid(vld_d1), .q(side1_q)
	);

	logic signed [W-1:0]   d1_d1 [3];
	logic signed [DLW-1:0] dl_d1 [3];

	assign {d1_d1[0], d1_d1[1], d1_d1[2], dl_d1[0], dl_d1[1], dl_d1[2]} = side1_q;

	// ---- stage 2: cross differences, parallel and zero checks ----
	logic signed [VW-1:0]  v_s2  [3];
	logic signed [VW-1:0]  w_s2  [3];
	logic signed [W-1:0]   d1_s2 [3];
	logic signed [DLW-1:0] dl_s2 [3];
	logic                  par_s2;
	logic                  z1_s2;
	logic                  vld_s2;
	logic signed [VW-1:0]  v_c   [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v_c[i] = VW'(pva[i]) - VW'(pvb[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (pipe_en) begin
			vld_s2 <= vld_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int i = 0; i < 3; i++) begin
				v_s2[i]  <= v_c[i];
				w_s2[i]  <= VW'(pwa[i]) - VW'(pwb[i]);
				d1_s2[i] <= d1_d1[i];
				dl_s2[i] <= dl_d1[i];
			end
			par_s2 <= (v_c[0] == '0) && (v_c[1] == '0) && (v_c[2] == '0);
			z1_s2  <= (d1_d1[0] == '0) && (d1_d1[1] == '0) && (d1_d1[2] == '0);
		end
	end

	// ---- layer 2: shared squares and products ----
	// skew:     sq = v*v (den), x = dl*v (dot terms)
	// parallel: sq = w*w (num), x = d1*d1 (den)
	logic signed [VW-1:0]   sq_op [3];
	logic signed [VW-1:0]   xa_op [3];
	logic signed [VW-1:0]   xb_op [3];
	logic signed [2*VW-1:0] psq   [3];
	logic signed [2*VW-1:0] px    [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_op[i] = par_s2 ? w_s2[i] : v_s2[i];
			xa_op[i] = par_s2 ? VW'(d1_s2[i]) : VW'(dl_s2[i]);
			xb_op[i] = par_s2 ? VW'(d1_s2[i]) : v_s2[i];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_l2
		rrd_mul #(.AW(VW), .BW(VW)) u_sq (
			.clk(clk), .en(pipe_en), .a(sq_op[i]), .b(sq_op[i]), .p(psq[i])
		);
		rrd_mul #(.AW(VW), .BW(VW)) u_x (
			.clk(clk), .en(pipe_en), .a(xa_op[i]), .b(xb_op[i]), .p(px[i])
		);
	end

	logic [1:0] side2_q;
	logic       vld_d2;

	rrd_dly #(.DW(2), .N(L2)) u_dly2 (
		.clk(clk), .arst_n(arst_n), .en(pipe_en),
		.in_valid(vld_s2), .d({z1_s2, par_s2}), .out_valid(vld_d2), .q(side2_q)
	);

	// ---- stage 3: sums ----
	logic signed [SW-1:0] ssq_s3;
	logic signed [SW-1:0] sx_s3;
	logic                 z1_s3;
	logic                 par_s3;
	logic                 vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (pipe_en) begin
			vld_s3 <= vld_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ssq_s3 <= SW'(psq[0]) + SW'(psq[1]) + SW'(psq[2]);
			sx_s3  <= SW'(px[0]) + SW'(px[1]) + SW'(px[2]);
			{z1_s3, par_s3} <= side2_q;
		end
	end

	// ---- layer 3: dot product squared ----
	logic signed [NW-1:0] pdot;

	rrd_mul #(.AW(SW), .BW(SW)) u_dot (
		.clk(clk), .en(pipe_en), .a(sx_s3), .b(sx_s3), .p(pdot)
	);

	logic [2*SW+1:0] side3_q;
	logic            vld_d3;
	logic [SW-1:0]   ssq_d3;
	logic [SW-1:0]   sx_d3;
	logic            z1_d3;
	logic            par_d3;

	rrd_dly #(.DW(2*SW+2), .N(L3)) u_dly3 (
		.clk(clk), .arst_n(arst_n), .en(pipe_en),
		.in_valid(vld_s3), .d({ssq_s3, sx_s3, z1_s3, par_s3}),
		.out_valid(vld_d3), .q(side3_q)
	);

	assign {ssq_d3, sx_d3, z1_d3, par_d3} = side3_q;

	// ---- stage 4: numerator and denominator select ----
	logic [NW-1:0] num_s4;
	logic [SW-1:0] den_s4;
	logic          z1_s4;
	logic          par_s4;
	logic          vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (pipe_en) begin
			vld_s4 <= vld_d3;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			num_s4 <= par_d3 ? NW'(ssq_d3) : pdot;
			den_s4 <= par_d3 ? sx_d3 : ssq_d3;
			z1_s4  <= z1_d3;
			par_s4 <= par_d3;
		end
	end

	// ---- root unit ----
	logic [DIST_W-1:0] root_r;
	logic              sat_r;
	logic [1:0]        side4_q;
	logic              vld_d4;

	rrd_root #(.NW(NW), .DW(SW)) u_root (
		.clk(clk), .en(pipe_en), .num(num_s4), .den(den_s4),
		.root(root_r), .sat(sat_r)
	);

	rrd_dly #(.DW(2), .N(ROOT_LAT)) u_dly4 (
		.clk(clk), .arst_n(arst_n), .en(pipe_en),
		.in_valid(vld_s4), .d({z1_s4, par_s4}), .out_valid(vld_d4), .q(side4_q)
	);

	// ---- stage 5: output register ----
	logic [DIST_W-1:0] dist_s5;
	rrd_status_t       stat_s5;
	logic              vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (pipe_en) begin
			vld_s5 <= vld_d4;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			if (side4_q[1]) begin
				dist_s5 <= '0;
				stat_s5 <= ST_ZERO;
			end else if (sat_r) begin
				dist_s5 <= '1;
				stat_s5 <= ST_SAT;
			end else begin
				dist_s5 <= root_r;
				stat_s5 <= side4_q[0] ? ST_PAR : ST_SKEW;
			end
		end
	end

	assign dist_valid = vld_s5;
	assign distance   = dist_s5;
	assign status     = stat_s5;

`ifndef SYNTHESIS
	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && (stat_s5 == ST_ZERO) |-> distance == '0)
		else $error("zero first direction with nonzero distance");

	a_sat_dist: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && (stat_s5 == ST_SAT) |-> distance == '1)
		else $error("saturated item without full-scale distance");

	a_zero_par: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && z1_s4 |-> par_s4)
		else $error("zero first direction not seen as parallel");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(vld_s4) && $stable(vld_s1))
		else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/ray_ray_distance_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ray_ray_distance_test
// Self-checking bench for the ray/ray line distance pipeline: a directed
// table of ray pairs followed by random pairs, with random gaps on the input
// and random stalls on the output, checked against an exact-integer model.
// ---------------------------------------------------------------------------
module ray_ray_distance_test
	import rrd_pkg::*;
();

	localparam int CW = 32;
	localparam int N_RANDOM = 1600;
	localparam int N_DIRECTED = 14;

	typedef logic signed [CW-1:0] coord_t;
	localparam coord_t CMAX = 32'sh7fffffff;
	localparam coord_t CMIN = 32'sh80000000;
	localparam coord_t ONE = 32'sh00010000;

	typedef struct {
		logic [DIST_W-1:0] dist_val;
		rrd_status_t       st;
	} line_dist_t;

	// o1 xyz, d1 xyz, o2 xyz, d2 xyz
	typedef struct {
		coord_t            c [12];
		bit                typed;
		logic [DIST_W-1:0] dist_val;
		rrd_status_t       st;
	} ray_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic ray_valid = 1'b0;
	logic ray_ready;
	logic dist_valid;
	logic dist_ready = 1'b0;
	logic [DIST_W-1:0] distance;
	logic [STAT_W-1:0] status;

	coord_t cur [12];
	bit cur_typed = 1'b0;
	line_dist_t cur_typed_res;

	line_dist_t pending_dist [$];
	int errors = 0;
	int n_sent = 0;
	int n_got = 0;
	int st_seen [4];
	bit send_done = 1'b0;
	bit rx_burst = 1'b0;

	ray_row_t dir_rows [N_DIRECTED];

	always #2 clk = ~clk;

	ray_ray_distance i_dut (
		.clk(clk), .arst_n(arst_n),
		.ray_valid(ray_valid), .ray_ready(ray_ready),
		.first_origin_x(cur[0]), .first_origin_y(cur[1]), .first_origin_z(cur[2]),
		.first_dir_x(cur[3]), .first_dir_y(cur[4]), .first_dir_z(cur[5]),
		.second_origin_x(cur[6]), .second_origin_y(cur[7]), .second_origin_z(cur[8]),
		.second_dir_x(cur[9]), .second_dir_y(cur[10]), .second_dir_z(cur[11]),
		.dist_valid(dist_valid), .dist_ready(dist_ready),
		.distance(distance), .status(status)
	);

	// exact line distance, truncated, saturated at the 32-bit maximum
	function automatic line_dist_t line_distance(input coord_t c [12]);
		logic signed [255:0] o1 [3], d1 [3], o2 [3], d2 [3], dl [3], v [3], w [3];
		logic signed [255:0] dotp;
		logic [255:0] num, den, sq;
		logic [31:0] r, t;
		line_dist_t res;
		for (int i = 0; i < 3; i++) begin
			o1[i] = c[i];
			d1[i] = c[3+i];
			o2[i] = c[6+i];
			d2[i] = c[9+i];
			dl[i] = o2[i] - o1[i];
		end
		if (d1[0] == 0 && d1[1] == 0 && d1[2] == 0) begin
			res.dist_val = '0;
			res.st = ST_ZERO;
			return res;
		end
		v[0] = d1[1] * d2[2] - d1[2] * d2[1];
		v[1] = d1[2] * d2[0] - d1[0] * d2[2];
		v[2] = d1[0] * d2[1] - d1[1] * d2[0];
		if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
			// parallel: |delta x d1|^2 / |d1|^2
			w[0] = dl[1] * d1[2] - dl[2] * d1[1];
			w[1] = dl[2] * d1[0] - dl[0] * d1[2];
			w[2] = dl[0] * d1[1] - dl[1] * d1[0];
			num = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
			den = d1[0] * d1[0] + d1[1] * d1[1] + d1[2] * d1[2];
			res.st = ST_PAR;
		end else begin
			dotp = dl[0] * v[0] + dl[1] * v[1] + dl[2] * v[2];
			num = dotp * dotp;
			den = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
			res.st = ST_SKEW;
		end
		if ((den << 64) <= num) begin
			res.dist_val = '1;
			res.st = ST_SAT;
			return res;
		end
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (32'd1 << b);
			sq = {224'd0, t};
			sq = sq * sq;
			if (sq * den <= num) r = t;
		end
		res.dist_val = r;
		return res;
	endfunction

	function automatic coord_t rand_coord(input int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 8000)) - 4000;
			2: return coord_t'($urandom_range(0, 400000)) - 200000;
			default: begin
				case ($urandom_range(0, 4))
					0: return CMAX;
					1: return CMIN;
					2: return '0;
					3: return coord_t'(-1);
					default: return ONE;
				endcase
			end
		endcase
	endfunction

	// random ray pair, mostly well-formed geometry with random content
	task automatic make_random(output coord_t c [12]);
		int kind, mode, k;
		kind = $urandom_range(0, 9);
		mode = $urandom_range(0, 3);
		for (int i = 0; i < 12; i++) c[i] = rand_coord(kind < 2 ? 0 : mode);
		case (kind)
			2, 3: begin
				// parallel: second direction a multiple of the first
				k = $urandom_range(0, 10) - 5;
				for (int i = 0; i < 3; i++) begin
					c[3+i] = rand_coord(1);
					c[9+i] = c[3+i] * k;
				end
			end
			4: for (int i = 0; i < 3; i++) c[3+i] = '0;
			5: for (int i = 0; i < 3; i++) c[9+i] = '0;
			6: begin
				// axis-aligned first direction
				for (int i = 0; i < 3; i++) c[3+i] = '0;
				c[3 + $urandom_range(0, 2)] = rand_coord($urandom_range(0, 3));
			end
			default: ;
		endcase
	endtask

	task automatic idle_gap(input bit burst);
		int n;
		if (burst) return;
		n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 40);
		if (n == 0) return;
		ray_valid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_item(input coord_t c [12], input bit typed, input line_dist_t tres);
		cur = c;
		cur_typed = typed;
		cur_typed_res = tres;
		ray_valid = 1'b1;
		@(posedge clk);
		while (!ray_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// directed rows
	initial begin
		for (int r = 0; r < N_DIRECTED; r++) begin
			for (int i = 0; i < 12; i++) dir_rows[r].c[i] = '0;
			dir_rows[r].typed = 1'b0;
			dir_rows[r].dist_val = '0;
			dir_rows[r].st = ST_SKEW;
		end
		// all zero: zero first direction
		dir_rows[0].typed = 1'b1; dir_rows[0].st = ST_ZERO;
		// zero first direction with extreme everything else
		for (int i = 0; i < 12; i++) dir_rows[1].c[i] = (i % 2) ? CMAX : CMIN;
		dir_rows[1].c[3] = '0; dir_rows[1].c[4] = '0; dir_rows[1].c[5] = '0;
		dir_rows[1].typed = 1'b1; dir_rows[1].st = ST_ZERO;
		// parallel along x, offset 5 in y
		dir_rows[2].c[3] = ONE; dir_rows[2].c[7] = 5 * ONE; dir_rows[2].c[9] = ONE;
		dir_rows[2].typed = 1'b1; dir_rows[2].dist_val = 32'd327680;
		dir_rows[2].st = ST_PAR;
		// skew: x line and y line, 3 apart in z
		dir_rows[3].c[3] = ONE; dir_rows[3].c[8] = 3 * ONE; dir_rows[3].c[10] = ONE;
		dir_rows[3].typed = 1'b1; dir_rows[3].dist_val = 32'd196608;
		dir_rows[3].st = ST_SKEW;
		// saturated: parallel, offset at full range in y and z
		dir_rows[4].c[3] = ONE; dir_rows[4].c[9] = ONE;
		dir_rows[4].c[1] = CMIN; dir_rows[4].c[2] = CMIN;
		dir_rows[4].c[7] = CMAX; dir_rows[4].c[8] = CMAX;
		dir_rows[4].typed = 1'b1; dir_rows[4].dist_val = '1; dir_rows[4].st = ST_SAT;
		// identical lines: distance zero
		dir_rows[5].c[3] = ONE; dir_rows[5].c[4] = ONE; dir_rows[5].c[9] = -ONE;
		dir_rows[5].c[10] = -ONE;
		dir_rows[5].typed = 1'b1; dir_rows[5].st = ST_PAR;
		// remaining rows go to the predictor
		for (int i = 0; i < 12; i++) dir_rows[6].c[i] = CMAX;
		for (int i = 0; i < 12; i++) dir_rows[7].c[i] = CMIN;
		for (int i = 0; i < 12; i++) dir_rows[8].c[i] = (i % 2) ? CMIN : CMAX;
		// zero second direction: parallel
		for (int i = 0; i < 9; i++) dir_rows[9].c[i] = coord_t'(i * 70000 - 300000);
		// extreme directions, small origins
		dir_rows[10].c[3] = CMAX; dir_rows[10].c[4] = CMIN; dir_rows[10].c[5] = 1;
		dir_rows[10].c[9] = CMIN; dir_rows[10].c[10] = CMAX; dir_rows[10].c[11] = -1;
		dir_rows[10].c[6] = ONE;
		// tiny directions, large offset
		dir_rows[11].c[3] = 1; dir_rows[11].c[10] = 1; dir_rows[11].c[11] = 1;
		dir_rows[11].c[0] = CMIN; dir_rows[11].c[8] = CMAX;
		// antiparallel extremes
		dir_rows[12].c[3] = CMAX; dir_rows[12].c[9] = CMIN + 1;
		dir_rows[12].c[6] = 1; dir_rows[12].c[7] = -1;
		// all ones except the second direction x
		for (int i = 0; i < 12; i++) dir_rows[13].c[i] = coord_t'(-1);
		dir_rows[13].c[9] = 7;
	end

	// input side
	initial begin
		coord_t c [12];
		line_dist_t tres;
		bit burst;
		for (int i = 0; i < 12; i++) cur[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int r = 0; r < N_DIRECTED; r++) begin
			idle_gap(1'b0);
			tres.dist_val = dir_rows[r].dist_val;
			tres.st = dir_rows[r].st;
			send_item(dir_rows[r].c, dir_rows[r].typed, tres);
		end
		burst = 1'b0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 200 == 0) begin
				burst = ($urandom_range(0, 2) == 0);
				rx_burst = ($urandom_range(0, 2) == 0);
			end
			idle_gap(burst);
			make_random(c);
			send_item(c, 1'b0, tres);
		end
		ray_valid = 1'b0;
		send_done = 1'b1;
	end

	// output side stalls
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (!arst_n) dist_ready = 1'b0;
			else if (stall > 0) begin
				dist_ready = 1'b0;
				stall--;
			end else begin
				dist_ready = 1'b1;
				if (!rx_burst && $urandom_range(0, 3) == 0)
					stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
						: $urandom_range(4, 40);
			end
		end
	end

	// accept and check at the rising edge
	always @(posedge clk) begin
		line_dist_t want;
		if (arst_n && ray_valid && ray_ready) begin
			pending_dist.push_back(cur_typed ? cur_typed_res : line_distance(cur));
			n_sent++;
		end
		if (arst_n && dist_valid && dist_ready) begin
			n_got++;
			st_seen[status]++;
			if (pending_dist.size() == 0) begin
				$error("distance item with nothing expected");
				errors++;
			end else begin
				want = pending_dist.pop_front();
				if (distance !== want.dist_val) begin
					$error("distance: expected %h, got %h", want.dist_val, distance);
					errors++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					errors++;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (send_done);
		while (pending_dist.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (pending_dist.size() != 0) begin
			$error("%0d distance items never arrived", pending_dist.size());
			errors++;
		end
		$display("Sent %0d ray pairs, checked %0d distances, %0d mismatches.",
			n_sent, n_got, errors);
		$display("Status mix: skew %0d, parallel %0d, zero dir %0d, saturated %0d.",
			st_seen[ST_SKEW], st_seen[ST_PAR], st_seen[ST_ZERO], st_seen[ST_SAT]);
		if (errors == 0)
			$display("** ray_ray_distance: PASSED **");
		else
			$display("** ray_ray_distance: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#4ms;
		$display("** ray_ray_distance: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/rrd_pkg.sv
hdl/rrd_dly.sv
hdl/rrd_mul.sv
hdl/rrd_root.sv
hdl/ray_ray_distance.sv
tb/sv/ray_ray_distance_test.sv
